// File: rtl/pam_pkg.sv
// ----------------------------------------------------------------------------
// pam_pkg
// Shared types, codes and constants of the polynomial add/multiply block.
// ----------------------------------------------------------------------------
package pam_pkg;

	// power field reaches 15, so at most 16 coefficients take part in a run
	localparam int POWER_SPAN    = 16;
	localparam int MAX_TERMS_DEF = 16;
	localparam int COEF_W        = 16;
	localparam int ACC_W         = 40;
	localparam int MAC_W         = 33;
	localparam int CNT_W         = 5;

	localparam logic [2:0] MODE_LOAD_A = 3'd0;
	localparam logic [2:0] MODE_LOAD_B = 3'd1;
	localparam logic [2:0] MODE_CLEAR  = 3'd2;
	localparam logic [2:0] MODE_SUM    = 3'd3;
	localparam logic [2:0] MODE_PROD   = 3'd4;

	typedef struct packed {
		logic [2:0]               mode;
		logic [3:0]               power;
		logic signed [COEF_W-1:0] coefficient;
	} req_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] result_coefficient;
		logic [4:0]              result_power;
		logic                    last;
	} rsp_t;

	// sequencer -> datapath
	typedef struct packed {
		logic             iss_valid;
		logic             iss_first;
		logic             iss_lastm;
		logic             is_sum;
		logic [CNT_W-1:0] addr_a;
		logic [CNT_W-1:0] addr_b;
		logic             emit;
		logic [CNT_W-1:0] power;
		logic             last;
	} ctl_t;

	// datapath -> sequencer
	typedef struct packed {
		logic done;
		logic free;
	} st_t;

endpackage

// File: rtl/pam_ram.sv
// ----------------------------------------------------------------------------
// pam_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pam_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/pam_seq.sv
// ----------------------------------------------------------------------------
// pam_seq
// Run sequencer: walks result powers downward and, per power, the index
// pairs that feed the shared multiply-accumulate.
// ----------------------------------------------------------------------------
module pam_seq #(
	parameter int MAX_TERMS = pam_pkg::MAX_TERMS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic [2:0]       req_mode,
	output logic             req_ready,
	input  pam_pkg::st_t     st,
	output pam_pkg::ctl_t    ctl
);

	localparam int SPAN = (MAX_TERMS < pam_pkg::POWER_SPAN) ? MAX_TERMS : pam_pkg::POWER_SPAN;
	localparam int CW   = pam_pkg::CNT_W;
	localparam logic [CW-1:0] TOP_I  = CW'(SPAN - 1);
	localparam logic [CW-1:0] P_PROD = CW'(2 * SPAN - 2);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] p_q;
	logic [CW-1:0] i_q;
	logic          sum_q;
	logic [CW-1:0] ilo_cur;
	logic [CW-1:0] ihi_cur;
	logic [CW-1:0] p_dec;
	logic [CW-1:0] ilo_dec;
	logic          start;
	logic          first;
	logic          lastm;

	// product terms at power p pair i with p-i, i limited to [ilo, ihi]
	assign ilo_cur = (p_q > TOP_I) ? p_q - TOP_I : '0;
	assign ihi_cur = (p_q < TOP_I) ? p_q : TOP_I;
	assign p_dec   = p_q - CW'(1);
	assign ilo_dec = (p_dec > TOP_I) ? p_dec - TOP_I : '0;

	assign req_ready = (state_q == ST_IDLE);
	assign start     = req_valid && req_ready &&
	                   (req_mode == pam_pkg::MODE_SUM || req_mode == pam_pkg::MODE_PROD);
	assign first     = sum_q || (i_q == ilo_cur);
	assign lastm     = sum_q || (i_q == ihi_cur);

	always_comb begin
		ctl           = '0;
		ctl.iss_valid = (state_q == ST_ISSUE);
		ctl.iss_first = first;
		ctl.iss_lastm = lastm;
		ctl.is_sum    = sum_q;
		ctl.addr_a    = i_q;
		ctl.addr_b    = sum_q ? p_q : p_q - i_q;
		ctl.emit      = (state_q == ST_FLUSH) && st.done && st.free;
		ctl.power     = p_q;
		ctl.last      = (p_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			p_q     <= '0;
			i_q     <= '0;
			sum_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						sum_q   <= (req_mode == pam_pkg::MODE_SUM);
						p_q     <= (req_mode == pam_pkg::MODE_SUM) ? TOP_I : P_PROD;
						i_q     <= TOP_I;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (lastm) begin
						state_q <= ST_FLUSH;
					end else begin
						i_q <= i_q + CW'(1);
					end
				end
				ST_FLUSH: begin
					if (ctl.emit) begin
						if (p_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							p_q     <= p_dec;
							i_q     <= sum_q ? p_dec : ilo_dec;
							state_q <= ST_ISSUE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE) |-> (ctl.addr_a <= TOP_I && ctl.addr_b <= TOP_I))
		else $error("read address beyond polynomial span");

endmodule

// File: rtl/pam_dp.sv
// ----------------------------------------------------------------------------
// pam_dp
// Multiply/add, accumulate and output register stage.
// ----------------------------------------------------------------------------
module pam_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pam_pkg::ctl_t                      ctl,
	input  logic signed [pam_pkg::COEF_W-1:0]  a_data,
	input  logic signed [pam_pkg::COEF_W-1:0]  b_data,
	input  logic                               a_ok,
	input  logic                               b_ok,
	output pam_pkg::st_t                       st,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output pam_pkg::rsp_t                      rsp
);

	localparam int CW = pam_pkg::COEF_W;
	localparam int MW = pam_pkg::MAC_W;
	localparam int AW = pam_pkg::ACC_W;

	logic                 vld_s1;
	logic                 first_s1;
	logic                 lastm_s1;
	logic                 sum_s1;
	logic                 vld_s2;
	logic                 first_s2;
	logic                 lastm_s2;
	logic signed [MW-1:0] mac_s2;
	logic signed [AW-1:0] acc_q;
	logic                 done_q;
	logic                 out_valid_q;
	pam_pkg::rsp_t        out_q;

	logic signed [CW-1:0]   op_a;
	logic signed [CW-1:0]   op_b;
	logic signed [2*CW-1:0] mul;
	logic signed [CW:0]     add;
	logic signed [MW-1:0]   mac_in;
	logic signed [AW-1:0]   mac_ext;

	// entries never written since reset or clear read as zero
	assign op_a    = a_ok ? a_data : '0;
	assign op_b    = b_ok ? b_data : '0;
	assign mul     = op_a * op_b;
	assign add     = (CW+1)'(op_a) + (CW+1)'(op_b);
	assign mac_in  = sum_s1 ? MW'(add) : MW'(mul);
	assign mac_ext = AW'(mac_s2);

	assign st.done   = done_q;
	assign st.free   = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= ctl.iss_valid;
			vld_s2 <= vld_s1;
			if (vld_s2 && lastm_s2) begin
				done_q <= 1'b1;
			end else if (ctl.emit) begin
				done_q <= 1'b0;
			end
			if (ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= ctl.iss_first;
		lastm_s1 <= ctl.iss_lastm;
		sum_s1   <= ctl.is_sum;
		first_s2 <= first_s1;
		lastm_s2 <= lastm_s1;
		mac_s2   <= mac_in;
		if (vld_s2) begin
			acc_q <= first_s2 ? mac_ext : acc_q + mac_ext;
		end
		if (ctl.emit) begin
			out_q.result_coefficient <= acc_q;
			out_q.result_power       <= ctl.power;
			out_q.last               <= ctl.last;
		end
	end

	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> done_q)
		else $error("result emitted before its accumulation finished");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> (!out_valid_q || rsp_ready))
		else $error("result register overwritten while still held");

	a_acc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> !done_q)
		else $error("accumulator updated while a finished term waits");

endmodule

// File: rtl/polynomial_add_multiply.sv
// Two polynomials of up to 16 terms live in two small RAMs, cleared through
// per-entry valid bits. Load and clear requests are taken only while no run
// is active. A sum request streams its terms from the highest power down,
// each term passing read, add, accumulate and hand-off. A product request
// runs every coefficient pair through one shared 16x16 multiplier, one pair
// per cycle while a result term accumulates, then hands that term off. New
// requests are taken once the last term sits in the output register; a
// stalled output holds the run. SPAN is min(MAX_TERMS, 16).
// ----------------------------------------------------------------------------
// polynomial_add_multiply
// Polynomial store with sum and product (convolution) result streams.
// ----------------------------------------------------------------------------
module polynomial_add_multiply #(
	parameter int MAX_TERMS = pam_pkg::MAX_TERMS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  pam_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output pam_pkg::rsp_t rsp
);

	localparam int AW = $clog2(MAX_TERMS);
	localparam int CW = pam_pkg::COEF_W;

	pam_pkg::ctl_t  ctl;
	pam_pkg::st_t   st;
	logic           req_acc;
	logic           in_range;
	logic [5:0]     pow_ext;
	logic [AW-1:0]  waddr;
	logic           we_a;
	logic           we_b;
	logic [AW-1:0]  raddr_a;
	logic [AW-1:0]  raddr_b;
	logic [CW-1:0]  rdata_a;
	logic [CW-1:0]  rdata_b;
	logic [MAX_TERMS-1:0] vld_a_q;
	logic [MAX_TERMS-1:0] vld_b_q;
	logic           a_ok_s1;
	logic           b_ok_s1;

	assign req_acc  = req_valid && req_ready;
	assign pow_ext  = {2'b00, req.power};
	assign in_range = (pow_ext < 6'(MAX_TERMS));
	assign waddr    = pow_ext[AW-1:0];
	assign we_a     = req_acc && (req.mode == pam_pkg::MODE_LOAD_A) && in_range;
	assign we_b     = req_acc && (req.mode == pam_pkg::MODE_LOAD_B) && in_range;
	assign raddr_a  = ctl.addr_a[AW-1:0];
	assign raddr_b  = ctl.addr_b[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_a_q <= '0;
			vld_b_q <= '0;
		end else begin
			if (req_acc && req.mode == pam_pkg::MODE_CLEAR) begin
				vld_a_q <= '0;
				vld_b_q <= '0;
			end
			if (we_a) begin
				vld_a_q[waddr] <= 1'b1;
			end
			if (we_b) begin
				vld_b_q[waddr] <= 1'b1;
			end
		end
	end

	// valid flags are registered like the RAM read data, so they arrive alongside it
	always_ff @(posedge clk) begin
		a_ok_s1 <= vld_a_q[raddr_a];
		b_ok_s1 <= vld_b_q[raddr_b];
	end

	pam_ram #(
		.WIDTH (CW),
		.DEPTH (MAX_TERMS)
	) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (req.coefficient),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	pam_ram #(
		.WIDTH (CW),
		.DEPTH (MAX_TERMS)
	) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (req.coefficient),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	pam_seq #(
		.MAX_TERMS (MAX_TERMS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_mode  (req.mode),
		.req_ready (req_ready),
		.st        (st),
		.ctl       (ctl)
	);

	pam_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.a_data    (rdata_a),
		.b_data    (rdata_b),
		.a_ok      (a_ok_s1),
		.b_ok      (b_ok_s1),
		.st        (st),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
